// File: rtl/core/hfa_pkg.sv
package hfa_pkg;

    // Table geometry
    localparam int HOLES     = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_BITS  = $clog2(HOLES);
    localparam int CNT_BITS  = $clog2(HOLES + 1);

    // Stream payload widths (packed, padded to whole bytes)
    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 40;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int POLICY_BITS   = 2;
    localparam int COUNT_BITS    = 5;

    // Register select (paddr[2])
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // Fit policy codes
    localparam logic [POLICY_BITS-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_BITS-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_BITS-1:0] POL_WORST = 2'd2;

    // Item kind codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Reset values of the registers
    localparam logic [POLICY_BITS-1:0] POLICY_RESET = POL_FIRST;
    localparam logic [COUNT_BITS-1:0]  COUNT_RESET  = COUNT_BITS'(HOLES);

    // Memory access from the sequencer
    typedef struct packed {
        logic                 we;
        logic [IDX_BITS-1:0]  waddr;
        logic [SIZE_BITS-1:0] wdata;
        logic                 re;
        logic [IDX_BITS-1:0]  raddr;
    } mem_req_t;

    // One allocate result
    typedef struct packed {
        logic                 granted;
        logic [IDX_BITS-1:0]  index;
        logic [SIZE_BITS-1:0] size_before;
        logic [SIZE_BITS-1:0] size_after;
    } result_t;

endpackage

// File: rtl/core/hfa_mem.sv
module hfa_mem
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  hfa_pkg::mem_req_t              mem_req,
    output logic [hfa_pkg::SIZE_BITS-1:0]  rd_data
);

    logic [hfa_pkg::SIZE_BITS-1:0] mem [hfa_pkg::HOLES];
    logic [hfa_pkg::HOLES-1:0]     valid_reg;
    logic [hfa_pkg::SIZE_BITS-1:0] rd_data_reg;

    // Mark written entries; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_req.we)
        begin
            valid_reg[mem_req.waddr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_data_reg <= valid_reg[mem_req.raddr] ? mem[mem_req.raddr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/hfa_seq.sv
module hfa_seq
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_func,
    input  logic [hfa_pkg::IDX_BITS-1:0]      in_index,
    input  logic [hfa_pkg::SIZE_BITS-1:0]     in_amount,
    input  logic [hfa_pkg::POLICY_BITS-1:0]   fit_policy,
    input  logic [hfa_pkg::COUNT_BITS-1:0]    hole_count,
    output hfa_pkg::mem_req_t                 mem_req,
    input  logic [hfa_pkg::SIZE_BITS-1:0]     rd_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output hfa_pkg::result_t                  res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [hfa_pkg::SIZE_BITS-1:0]       req_reg, req_next;
    logic [hfa_pkg::POLICY_BITS-1:0]     pol_reg, pol_next;
    logic [hfa_pkg::CNT_BITS-1:0]        n_reg, n_next;
    logic [hfa_pkg::CNT_BITS-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                                rvalid_reg, rvalid_next;
    logic [hfa_pkg::IDX_BITS-1:0]        ridx_reg, ridx_next;
    logic                                found_reg, found_next;
    logic [hfa_pkg::IDX_BITS-1:0]        best_idx_reg, best_idx_next;
    logic [hfa_pkg::SIZE_BITS-1:0]       best_val_reg, best_val_next;

    logic                                accept;
    logic                                issue;
    logic                                take;
    logic                                grant;
    logic [hfa_pkg::CNT_BITS-1:0]        n_clamped;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == ST_SCAN) && (rd_ptr_reg < n_reg);

    // Saturate the entry count at the table depth
    assign n_clamped = (hole_count > hfa_pkg::COUNT_BITS'(hfa_pkg::HOLES))
                     ? hfa_pkg::CNT_BITS'(hfa_pkg::HOLES)
                     : hfa_pkg::CNT_BITS'(hole_count);

    // Decide whether the entry just read replaces the current pick
    always_comb
    begin
        case (pol_reg)
            hfa_pkg::POL_BEST:
                take = (rd_data >= req_reg) && (!found_reg || rd_data < best_val_reg);
            hfa_pkg::POL_WORST:
                take = !found_reg || (rd_data > best_val_reg);
            default:
                take = !found_reg && (rd_data >= req_reg);
        endcase
    end

    // Worst fit checks the largest hole against the request at the end
    assign grant = found_reg
                && ((pol_reg != hfa_pkg::POL_WORST) || (best_val_reg >= req_reg));

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        pol_next      = pol_reg;
        n_next        = n_reg;
        rd_ptr_next   = rd_ptr_reg;
        rvalid_next   = 1'b0;
        ridx_next     = ridx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_func == hfa_pkg::FUNC_ALLOC)
                begin
                    req_next      = in_amount;
                    pol_next      = fit_policy;
                    n_next        = n_clamped;
                    rd_ptr_next   = '0;
                    found_next    = 1'b0;
                    best_idx_next = '0;
                    best_val_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = rd_ptr_reg[hfa_pkg::IDX_BITS-1:0];
                end
                if (rvalid_reg && take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = ridx_reg;
                    best_val_next = rd_data;
                end
                if (!issue && !rvalid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Scan datapath
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pol_reg      <= pol_next;
        n_reg        <= n_next;
        rd_ptr_reg   <= rd_ptr_next;
        ridx_reg     <= ridx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
    end

    // Memory access: loads write on transfer, allocates write back the pick
    always_comb
    begin
        mem_req.re    = issue;
        mem_req.raddr = rd_ptr_reg[hfa_pkg::IDX_BITS-1:0];
        if (state_reg == ST_DONE)
        begin
            mem_req.we    = res_ready && grant;
            mem_req.waddr = best_idx_reg;
            mem_req.wdata = best_val_reg - req_reg;
        end
        else
        begin
            mem_req.we    = accept && (in_func == hfa_pkg::FUNC_LOAD);
            mem_req.waddr = in_index;
            mem_req.wdata = in_amount;
        end
    end

    // Result; zero fields when nothing fits
    assign res_valid       = (state_reg == ST_DONE);
    assign res.granted     = grant;
    assign res.index       = grant ? best_idx_reg : '0;
    assign res.size_before = grant ? best_val_reg : '0;
    assign res.size_after  = grant ? (best_val_reg - req_reg) : '0;

endmodule

// File: rtl/core/hole_table_fit_allocator.sv
// Load items write the hole table on transfer and cause no result.
// An allocate item reads the active entries (hole_count, capped at 16) one per cycle,
// then offers the result and writes back the chosen entry if granted. The next item is
// taken once the result has moved into the output register; while that register stays
// full, the result waits. Reset clears the hole table to zero, fit_policy to first fit,
// hole_count to 16, and empties the output register.
module hole_table_fit_allocator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hfa_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [hfa_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [hfa_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [hfa_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,  // hole_index[3:0], amount[19:4]
    input  logic                                 s_axis_tuser,  // func
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [hfa_pkg::M_TDATA_BITS-1:0]     m_axis_tdata,  // chosen_index[3:0],
                                                                // size_before[19:4],
                                                                // size_after[35:20]
    output logic                                 m_axis_tuser   // granted
);

    logic [hfa_pkg::POLICY_BITS-1:0]  fit_policy_reg;
    logic [hfa_pkg::COUNT_BITS-1:0]   hole_count_reg;
    logic                             cfg_write;

    hfa_pkg::mem_req_t                mem_req;
    logic [hfa_pkg::SIZE_BITS-1:0]    rd_data;
    logic                             res_valid;
    logic                             res_ready;
    hfa_pkg::result_t                 res;

    logic                             m_valid_reg;
    hfa_pkg::result_t                 m_data_reg;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= hfa_pkg::POLICY_RESET;
            hole_count_reg <= hfa_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == hfa_pkg::REG_POLICY)
            begin
                fit_policy_reg <= pwdata[hfa_pkg::POLICY_BITS-1:0];
            end
            else
            begin
                hole_count_reg <= pwdata[hfa_pkg::COUNT_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == hfa_pkg::REG_POLICY)
                  ? hfa_pkg::APB_DATA_BITS'(fit_policy_reg)
                  : hfa_pkg::APB_DATA_BITS'(hole_count_reg);

    hfa_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    hfa_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (s_axis_tuser),
        .in_index   (s_axis_tdata[hfa_pkg::IDX_BITS-1:0]),
        .in_amount  (s_axis_tdata[hfa_pkg::IDX_BITS +: hfa_pkg::SIZE_BITS]),
        .fit_policy (fit_policy_reg),
        .hole_count (hole_count_reg),
        .mem_req    (mem_req),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: take a new result when empty or draining
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_data_reg.granted;
    assign m_axis_tdata  = hfa_pkg::M_TDATA_BITS'({m_data_reg.size_after,
                                                   m_data_reg.size_before,
                                                   m_data_reg.index});

    // A granted hole never grows
    a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_data_reg.size_after <= m_data_reg.size_before))
        else $error("granted hole grew");

    // A refused request reports all-zero fields
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("refused request with nonzero fields");

    // An allocate transfer starts a scan that holds off the input
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == hfa_pkg::FUNC_ALLOC)
        |=> !s_axis_tready)
        else $error("input taken during scan");

    // No memory write while a scan reads the table
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |-> !mem_req.we)
        else $error("table written during scan");

endmodule
